/* hdl/button_press_duration_capture_top_assert.svh */
// assertion macros for the press-duration capture block
// used by the port property module, no other dependencies
`ifndef BUTTON_PRESS_DURATION_CAPTURE_TOP_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CAPTURE_TOP_ASSERT_SVH

// clocked assertion with explicit clock and active-low reset
`define BPDC_ASSERT_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define BPDC_ASSERT(lbl, prop, msg) \
	`BPDC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* hdl/bpdc_pkg.sv */
// shared types and constants of the press-duration capture block
// no dependencies
`timescale 1ns / 1ps

package bpdc_pkg;

	localparam int NUM_BUTTONS = 7;
	localparam int BTN_W       = 3;
	localparam int TIME_W      = 32;
	localparam int CNT_W       = 8;
	localparam int MIN_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// register reset values
	localparam logic [CNT_W-1:0] STABLE_COUNT_RST = 8'd20;
	localparam logic [MIN_W-1:0] MIN_PRESS_RST    = 16'd10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 2'd2;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic [NUM_BUTTONS-1:0]   levels;
		logic [TIME_W-1:0]        now_ms;
	} req_t;

	typedef struct packed {
		logic [BTN_W-1:0]  button;
		logic [TIME_W-1:0] duration_ms;
		logic              last;
	} rsp_t;

	// one drain: pending snapshot and the stored durations
	typedef struct packed {
		logic [NUM_BUTTONS-1:0]             mask;
		logic [NUM_BUTTONS-1:0][TIME_W-1:0] len;
	} drain_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// index of the lowest set bit
	function automatic logic [BTN_W-1:0] lowest_set(input logic [NUM_BUTTONS-1:0] m);
		logic [BTN_W-1:0] r;
		r = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (m[i]) r = BTN_W'(i);
		end
		return r;
	endfunction

endpackage

/* hdl/bpdc_queue.sv */
// short drain command queue between front and back
// depends on bpdc_pkg
`timescale 1ns / 1ps

module bpdc_queue import bpdc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  drain_cmd_t push_data,
	input  logic       pop,
	output drain_cmd_t head,
	output q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QC_W  = $clog2(DEPTH + 1);

	drain_cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QC_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + QC_W'(1);
			else if (pop && !push) count_q <= count_q - QC_W'(1);
		end
	end

endmodule

/* hdl/bpdc_front.sv */
// front end: config registers, per-line debounce and press timing, drain issue
// depends on bpdc_pkg
`timescale 1ns / 1ps

module bpdc_front import bpdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	input  q_stat_t               qstat,
	output logic                  push,
	output drain_cmd_t            push_data
);

	logic [CNT_W-1:0]       stable_q;
	logic [MIN_W-1:0]       min_press_q;
	logic [NUM_BUTTONS-1:0] enable_q;

	logic [NUM_BUTTONS-1:0] filt_q, filt_d;
	logic [NUM_BUTTONS-1:0] await_q, await_d;
	logic [NUM_BUTTONS-1:0] pend_q, pend_d;
	logic [CNT_W-1:0]       cnt_q [NUM_BUTTONS];
	logic [CNT_W-1:0]       cnt_d [NUM_BUTTONS];
	logic [TIME_W-1:0]      start_q [NUM_BUTTONS];
	logic [TIME_W-1:0]      start_d [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0][TIME_W-1:0] len_q, len_d;

	logic accept;
	logic sample;

	assign req_ready = !qstat.full;
	assign accept    = req_valid && req_ready;
	assign sample    = accept && (req.opcode == OP_SAMPLE);

	// drain issue: snapshot pending lines, skip when nothing is pending
	assign push           = accept && (req.opcode == OP_DRAIN) && (pend_q != '0);
	assign push_data.mask = pend_q;
	assign push_data.len  = len_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= STABLE_COUNT_RST;
			min_press_q <= MIN_PRESS_RST;
			enable_q    <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STABLE_COUNT: stable_q    <= cfg_data[CNT_W-1:0];
				CFG_MIN_PRESS_MS: min_press_q <= cfg_data[MIN_W-1:0];
				CFG_ENABLE_MASK:  enable_q    <= cfg_data[NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	// per-line debounce and press timing, lanes are independent
	always_comb begin
		logic [TIME_W-1:0] dur;
		filt_d  = filt_q;
		await_d = await_q;
		pend_d  = pend_q;
		len_d   = len_q;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			cnt_d[i]   = cnt_q[i];
			start_d[i] = start_q[i];
			dur        = req.now_ms - start_q[i];
			if (sample && enable_q[i] && !pend_q[i]) begin
				if (req.levels[i] == filt_q[i]) begin
					cnt_d[i] = '0;
				end else if (cnt_q[i] < stable_q) begin
					cnt_d[i] = cnt_q[i] + CNT_W'(1);
				end else begin
					cnt_d[i]  = '0;
					filt_d[i] = !filt_q[i];
					if (!req.levels[i]) begin
						start_d[i] = req.now_ms;
						await_d[i] = 1'b1;
					end else if (await_q[i] && (dur >= TIME_W'(min_press_q))) begin
						len_d[i]   = dur;
						pend_d[i]  = 1'b1;
						await_d[i] = 1'b0;
					end
				end
			end
		end
		if (push) pend_d = '0;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '1;
			await_q <= '0;
			pend_q  <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i]   <= '0;
				start_q[i] <= '0;
			end
		end else begin
			filt_q  <= filt_d;
			await_q <= await_d;
			pend_q  <= pend_d;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i]   <= cnt_d[i];
				start_q[i] <= start_d[i];
			end
		end
	end

	// stored durations, valid only where pending is set
	always_ff @(posedge clk) begin
		len_q <= len_d;
	end

endmodule

/* hdl/bpdc_back.sv */
// back end: walks one drain snapshot and emits one result beat per pending line
// depends on bpdc_pkg
`timescale 1ns / 1ps

module bpdc_back import bpdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    qstat,
	input  drain_cmd_t head,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	logic [NUM_BUTTONS-1:0]             mask_q;
	logic [NUM_BUTTONS-1:0][TIME_W-1:0] len_q;
	logic                               rsp_valid_q;
	rsp_t                               rsp_q;

	logic                   slot_free;
	logic                   emit;
	logic [BTN_W-1:0]       idx;
	logic [NUM_BUTTONS-1:0] rest;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign emit      = slot_free && (mask_q != '0);
	assign idx       = lowest_set(mask_q);
	assign rest      = mask_q & (mask_q - NUM_BUTTONS'(1));
	assign pop       = !qstat.empty && (mask_q == '0);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// active drain mask and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) mask_q <= head.mask;
			else if (emit) mask_q <= rest;
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) len_q <= head.len;
		if (emit) begin
			rsp_q.button      <= idx;
			rsp_q.duration_ms <= len_q[idx];
			rsp_q.last        <= (rest == '0);
		end
	end

endmodule

/* hdl/button_press_duration_capture_top.sv */
// sample beats are accepted every cycle while the queue has room
// a drain beat passes the queue and the back's mask register before its first result is registered,
// then one per cycle as the output register frees; the back walks pending lines at that rate
// asynchronous active-low reset resets line state, clears pending flags, queue and output valid
// and loads the register defaults; no clearing pass
// depends on bpdc_pkg, bpdc_front, bpdc_queue, bpdc_back
`timescale 1ns / 1ps

module button_press_duration_capture_top import bpdc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	q_stat_t    qstat;
	logic       push;
	logic       pop;
	drain_cmd_t push_data;
	drain_cmd_t head;

	assign cfg_ready = 1'b1;

	bpdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	bpdc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	bpdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* hdl/bpdc_props.sv */
// port-level properties of the press-duration capture block, bound to the top level
// depends on bpdc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "button_press_duration_capture_top_assert.svh"

module bpdc_props import bpdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled result beat holds
	`BPDC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result changed while stalled")

	// reported button is a real line
	`BPDC_ASSERT(a_btn_range, rsp_valid |-> (rsp.button < BTN_W'(NUM_BUTTONS)), "button index out of range")

	// buttons of one drain come in ascending order
	`BPDC_ASSERT(a_btn_order, (rsp_valid && rsp_ready && !rsp.last) ##1 rsp_valid |-> (rsp.button > $past(rsp.button)), "drain order broken")

endmodule

bind button_press_duration_capture_top bpdc_props u_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
